// ===== rtl/core/xhsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xhsa_pkg: shared types, constants and SHA-256 helpers
// Round constants, the initial hash value, the round function and the byte
// ordering used by the XOR hash set accumulator.
// ----------------------------------------------------------------------------
package xhsa_pkg;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef logic [31:0]        t_word;
    typedef t_word [7:0]        t_hstate;   // index 0 is working variable a
    typedef t_word [15:0]       t_window;   // index 0 is the word used next
    typedef logic [3:0][63:0]   t_acc;

    // One slot of the hash pipeline.
    typedef struct packed {
        t_hstate st;
        t_window win;
        t_op     op;
        logic    upd;
    } t_stage;

    // One entry of the queue between the hash front and the accumulator.
    typedef struct packed {
        t_acc dig;
        t_op  op;
        logic upd;
    } t_qent;

    localparam t_word K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_hstate H_INIT = '{
        0: 32'h6a09e667, 1: 32'hbb67ae85, 2: 32'h3c6ef372, 3: 32'ha54ff53a,
        4: 32'h510e527f, 5: 32'h9b05688c, 6: 32'h1f83d9ab, 7: 32'h5be0cd19
    };

    // Fixed padding of a 48-byte message: a one bit, zeros, length 384.
    localparam t_word PAD_WORD = 32'h8000_0000;
    localparam t_word LEN_WORD = 32'h0000_0180;

    function automatic t_word rotr(t_word x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word bswap(t_word x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Little-endian fields become big-endian message words.
    function automatic t_window msg_window(logic [3:0][63:0] id, logic [31:0] out_index,
                                           logic [63:0] amount, logic [31:0] height);
        t_window w;
        for (int i = 0; i < 4; i++) begin
            w[2*i]   = bswap(id[i][31:0]);
            w[2*i+1] = bswap(id[i][63:32]);
        end
        w[8]  = bswap(out_index);
        w[9]  = bswap(amount[31:0]);
        w[10] = bswap(amount[63:32]);
        w[11] = bswap(height);
        w[12] = PAD_WORD;
        w[13] = '0;
        w[14] = '0;
        w[15] = LEN_WORD;
        return w;
    endfunction

    // One compression round; the schedule window slides by one word.
    function automatic t_stage sha_round(t_stage s, t_word k);
        t_stage r;
        t_word  t1;
        t_word  t2;
        t_word  ch;
        t_word  maj;
        t_word  sg0;
        t_word  sg1;
        ch  = (s.st[4] & s.st[5]) ^ (~s.st[4] & s.st[6]);
        maj = (s.st[0] & s.st[1]) ^ (s.st[0] & s.st[2]) ^ (s.st[1] & s.st[2]);
        t1  = s.st[7] + (rotr(s.st[4], 6) ^ rotr(s.st[4], 11) ^ rotr(s.st[4], 25))
              + ch + k + s.win[0];
        t2  = (rotr(s.st[0], 2) ^ rotr(s.st[0], 13) ^ rotr(s.st[0], 22)) + maj;
        r       = s;
        r.st[0] = t1 + t2;
        r.st[1] = s.st[0];
        r.st[2] = s.st[1];
        r.st[3] = s.st[2];
        r.st[4] = s.st[3] + t1;
        r.st[5] = s.st[4];
        r.st[6] = s.st[5];
        r.st[7] = s.st[6];
        sg0 = rotr(s.win[1], 7) ^ rotr(s.win[1], 18) ^ (s.win[1] >> 3);
        sg1 = rotr(s.win[14], 17) ^ rotr(s.win[14], 19) ^ (s.win[14] >> 10);
        for (int i = 0; i < 15; i++) begin
            r.win[i] = s.win[i+1];
        end
        r.win[15] = sg1 + s.win[9] + sg0 + s.win[0];
        return r;
    endfunction

    // Digest bytes are taken big-endian from each state word and laid
    // into the accumulator words with byte 0 in the low bits.
    function automatic t_acc to_acc(t_hstate d);
        t_acc a;
        for (int i = 0; i < 4; i++) begin
            a[i] = {bswap(d[2*i+1]), bswap(d[2*i])};
        end
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/xhsa_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xhsa_ifs: channel interfaces
// Element input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
interface xhsa_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [63:0]        id_word0;
    logic [63:0]        id_word1;
    logic [63:0]        id_word2;
    logic [63:0]        id_word3;
    logic [31:0]        out_index;
    logic signed [63:0] amount;
    logic signed [31:0] chain_height;

    modport source (output valid, op, id_word0, id_word1, id_word2, id_word3,
                    out_index, amount, chain_height, input ready);
    modport sink   (input valid, op, id_word0, id_word1, id_word2, id_word3,
                    out_index, amount, chain_height, output ready);
endinterface

interface xhsa_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] acc_word0;
    logic [63:0] acc_word1;
    logic [63:0] acc_word2;
    logic [63:0] acc_word3;
    logic [63:0] element_count;

    modport source (output valid, acc_word0, acc_word1, acc_word2, acc_word3,
                    element_count, input ready);
    modport sink   (input valid, acc_word0, acc_word1, acc_word2, acc_word3,
                    element_count, output ready);
endinterface

interface xhsa_cfg_if;
    logic valid;
    logic ready;
    logic skip_updates;

    modport source (output valid, skip_updates, input ready);
    modport sink   (input valid, skip_updates, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/xhsa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xhsa_front: element intake and SHA-256 round pipeline
// Tags each element with its operation and whether it updates state, then
// runs it through one register stage per compression round.
// ----------------------------------------------------------------------------
module xhsa_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    xhsa_in_if.sink             i_in,
    xhsa_cfg_if.sink            i_cfg,
    input  wire                 i_q_full,
    output logic                o_q_push,
    output xhsa_pkg::t_qent     o_q_data
);
    import xhsa_pkg::*;

    logic                r_skip;
    logic [ROUNDS-1:0]   r_vld;
    t_stage              r_stg [ROUNDS];
    t_stage              n_stg [ROUNDS];
    t_stage              s_in;
    t_hstate             s_dig;
    logic                s_adv;

    // The whole pipeline moves together; it holds only when the last
    // stage has an element and the queue cannot take it.
    assign s_adv      = !r_vld[ROUNDS-1] || !i_q_full;
    assign i_in.ready = s_adv;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        s_in.st  = H_INIT;
        s_in.win = msg_window({i_in.id_word3, i_in.id_word2, i_in.id_word1, i_in.id_word0},
                              i_in.out_index, i_in.amount, i_in.chain_height);
        s_in.op  = t_op'(i_in.op);
        s_in.upd = !r_skip;
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        if (g == 0) begin : g_first
            assign n_stg[g] = sha_round(s_in, K_TAB[g]);
        end else begin : g_rest
            assign n_stg[g] = sha_round(r_stg[g-1], K_TAB[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
            r_vld  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_skip <= i_cfg.skip_updates;
            end
            if (s_adv) begin
                r_vld <= {r_vld[ROUNDS-2:0], i_in.valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_stg <= n_stg;
        end
    end

    // Feed-forward add of the initial hash value closes the block.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            s_dig[i] = r_stg[ROUNDS-1].st[i] + H_INIT[i];
        end
        o_q_data.dig = to_acc(s_dig);
        o_q_data.op  = r_stg[ROUNDS-1].op;
        o_q_data.upd = r_stg[ROUNDS-1].upd;
    end

    assign o_q_push = r_vld[ROUNDS-1] && s_adv;

endmodule
`default_nettype wire

// ===== rtl/core/xhsa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xhsa_queue: digest queue
// Short first-in first-out buffer between the hash front and the
// accumulator, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module xhsa_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  xhsa_pkg::t_qent     i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output xhsa_pkg::t_qent     o_data
);
    import xhsa_pkg::*;

    t_qent             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;
    logic              s_push;
    logic              s_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/xhsa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xhsa_back: accumulator and element count
// XORs each digest into the accumulator and steps the count when its entry
// updates state, and presents the state after every element as one result.
// ----------------------------------------------------------------------------
module xhsa_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  xhsa_pkg::t_qent     i_q_data,
    output logic                o_q_pop,
    xhsa_out_if.source          o_res
);
    import xhsa_pkg::*;

    t_acc        r_acc;
    logic [63:0] r_cnt;
    logic        r_out_vld;
    t_acc        n_acc;
    logic [63:0] n_cnt;
    logic        s_take;

    // The state registers double as the result payload: they change only
    // when a new element is taken, which needs the previous result gone.
    assign s_take  = i_q_valid && (!r_out_vld || o_res.ready);
    assign o_q_pop = s_take;

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_q_data.upd) begin
            n_acc = r_acc ^ i_q_data.dig;
            unique case (i_q_data.op)
                OP_ADD: begin
                    n_cnt = r_cnt + 64'd1;
                end
                OP_REMOVE: begin
                    // Removing from an empty set leaves the count at zero.
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 64'd1;
                    end
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_take) begin
                r_acc     <= n_acc;
                r_cnt     <= n_cnt;
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.acc_word0     = r_acc[0];
    assign o_res.acc_word1     = r_acc[1];
    assign o_res.acc_word2     = r_acc[2];
    assign o_res.acc_word3     = r_acc[3];
    assign o_res.element_count = r_cnt;

endmodule
`default_nettype wire

// ===== rtl/core/xor_hash_set_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xor_hash_set_accumulator: XOR multiset hash over SHA-256 digests
// Each element is packed into a 48-byte message, hashed with SHA-256 and,
// unless skip_updates is set, XORed into a 256-bit accumulator and counted.
//
//   Port     Dir   Carries
//   i_in     in    op, 32-byte id, out_index, amount, chain_height
//   i_cfg    in    skip_updates register write
//   o_res    out   acc_word0..3 and element_count after each element
//
// One element is taken per cycle unless the round pipeline is held; each
// element passes through the 64-stage round pipeline, the digest queue and
// the result register on its way to o_res.
// Reset is synchronous and active low; it clears the accumulator, the count,
// skip_updates and all pipeline and queue occupancy.
// A stall on o_res fills the four-entry queue, after which the round
// pipeline and i_in hold until the queue has room again.
// ----------------------------------------------------------------------------
module xor_hash_set_accumulator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    xhsa_in_if.sink     i_in,
    xhsa_cfg_if.sink    i_cfg,
    xhsa_out_if.source  o_res
);
    import xhsa_pkg::*;

    logic  s_push;
    logic  s_full;
    t_qent s_push_data;
    logic  s_pop;
    logic  s_q_valid;
    t_qent s_q_data;

    xhsa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (s_full),
        .o_q_push (s_push),
        .o_q_data (s_push_data)
    );

    xhsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_push_data),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_valid (s_q_valid),
        .o_data  (s_q_data)
    );

    xhsa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (s_q_valid),
        .i_q_data  (s_q_data),
        .o_q_pop   (s_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

// ===== test/xhsa_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xhsa_set_checker: result checker for the XOR hash set accumulator
// Watches the element, register and result channels. For every element
// transfer it queues the set state that the block must report, having first
// hashed the element with its own SHA-256 and folded the digest into a
// private accumulator and count unless skip_updates is set. Each result
// transfer is compared field by field with the oldest queued state.
// ----------------------------------------------------------------------------
module xhsa_set_checker
    import xhsa_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    xhsa_in_if   i_in,
    xhsa_cfg_if  i_cfg,
    xhsa_out_if  i_res,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int MAX_REPORTS = 10;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_SEED [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [3:0][63:0] acc;
        logic [63:0]      count;
    } t_set_state;

    logic [3:0][63:0] set_acc;
    logic [63:0]      set_count;
    logic             skip_model;
    t_set_state       pending_states[$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        logic [63:0] doubled;
        doubled = {x, x} >> n;
        return doubled[31:0];
    endfunction

    // SHA-256 of the 48-byte element message, with the digest bytes laid into
    // four little-endian accumulator words.
    function automatic logic [3:0][63:0] element_digest(input logic [3:0][63:0] id,
                                                        input logic [31:0] idx,
                                                        input logic [63:0] amt,
                                                        input logic [31:0] height);
        logic [7:0]       msg_block [64];
        logic [31:0]      sched [64];
        logic [31:0]      hv [8];
        logic [31:0]      a, b, c, d, e, f, g, h;
        logic [31:0]      t1, t2, sig0, sig1;
        logic [3:0][63:0] folded;
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        for (int w = 0; w < 4; w++) begin
            for (int k = 0; k < 8; k++) msg_block[8*w + k] = id[w][8*k +: 8];
        end
        for (int k = 0; k < 4; k++) begin
            msg_block[32 + k] = idx[8*k +: 8];
            msg_block[44 + k] = height[8*k +: 8];
        end
        for (int k = 0; k < 8; k++) msg_block[36 + k] = amt[8*k +: 8];
        // Padding: a single one bit after the message, then the length of
        // 384 bits in the last two bytes.
        msg_block[48] = 8'h80;
        msg_block[62] = 8'h01;
        msg_block[63] = 8'h80;
        for (int i = 0; i < 16; i++) begin
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            sig0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            sig1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + sig0 + sched[i-7] + sig1;
        end
        hv = HASH_SEED;
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + sched[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
        // Digest byte n is byte 3 - n%4 of state word n/4, counted from the low end.
        for (int w = 0; w < 4; w++) begin
            for (int k = 0; k < 8; k++) begin
                folded[w][8*k +: 8] = hv[2*w + k/4][8*(3 - k%4) +: 8];
            end
        end
        return folded;
    endfunction

    task automatic log_failure(input string msg);
        if (o_mismatches < MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
        o_mismatches++;
    endtask

    initial o_mismatches = 0;

    always @(posedge i_clk) begin
        t_set_state seen;
        t_set_state want;
        if (!i_rst_n) begin
            set_acc    = '0;
            set_count  = '0;
            skip_model = 1'b0;
            pending_states.delete();
        end else begin
            // Results are checked before this cycle's element is queued, so a
            // spurious result can never match a state that was only just predicted.
            if (i_res.valid && i_res.ready) begin
                seen.acc   = {i_res.acc_word3, i_res.acc_word2, i_res.acc_word1, i_res.acc_word0};
                seen.count = i_res.element_count;
                if (pending_states.size() == 0) begin
                    log_failure($sformatf("result transfer with nothing outstanding, count %0d",
                                          seen.count));
                end else begin
                    want = pending_states.pop_front();
                    for (int w = 0; w < 4; w++) begin
                        if (seen.acc[w] !== want.acc[w]) begin
                            log_failure($sformatf("acc_word%0d: expected %h, got %h",
                                                  w, want.acc[w], seen.acc[w]));
                        end
                    end
                    if (seen.count !== want.count) begin
                        log_failure($sformatf("element_count: expected %0d, got %0d",
                                              want.count, seen.count));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                skip_model = i_cfg.skip_updates;
            end
            if (i_in.valid && i_in.ready) begin
                if (!skip_model) begin
                    set_acc ^= element_digest({i_in.id_word3, i_in.id_word2,
                                               i_in.id_word1, i_in.id_word0},
                                              i_in.out_index, i_in.amount, i_in.chain_height);
                    if (i_in.op == OP_ADD) begin
                        set_count = set_count + 64'd1;
                    end else if (set_count != 64'd0) begin
                        set_count = set_count - 64'd1;
                    end
                end
                want.acc   = set_acc;
                want.count = set_count;
                pending_states.push_back(want);
            end
        end
        o_outstanding <= pending_states.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the XOR hash set accumulator
// Drives element transfers and skip_updates writes, stalls the result side,
// and reports the verdict from the checker's mismatch count. Directed
// elements cover field extremes, removal at zero count and frozen updates;
// random elements mostly add new members and remove earlier ones.
// ----------------------------------------------------------------------------
module testbench;
    import xhsa_pkg::*;

    localparam int STALL_PCT       = 16;
    localparam int RX_HOLD_CYCLES  = 160;
    localparam int TAIL_CYCLES     = 80;
    localparam int HISTORY_LIMIT   = 64;

    typedef struct packed {
        t_op              op;
        logic [3:0][63:0] id;
        logic [31:0]      out_index;
        logic [63:0]      amount;
        logic [31:0]      chain_height;
    } t_element;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    xhsa_in_if  elem_ch ();
    xhsa_cfg_if cfg_ch ();
    xhsa_out_if res_ch ();

    int mismatches;
    int outstanding;

    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;

    // Elements added earlier, kept so that random traffic can remove members.
    t_element member_history[$];

    xor_hash_set_accumulator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (elem_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    xhsa_set_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (elem_ch),
        .i_cfg         (cfg_ch),
        .i_res         (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_element make_element(input t_op op, input logic [63:0] id_fill,
                                              input logic [31:0] idx, input logic [63:0] amt,
                                              input logic [31:0] height);
        t_element el;
        el.op           = op;
        el.id           = {4{id_fill}};
        el.out_index    = idx;
        el.amount       = amt;
        el.chain_height = height;
        return el;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(19))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_element random_element();
        t_element    el;
        logic [63:0] r;
        int unsigned pick;
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 40 && member_history.size() != 0) begin
            // Take back a member that was added earlier.
            pick = $urandom_range(member_history.size() - 1);
            el = member_history[pick];
            member_history.delete(pick);
            el.op = OP_REMOVE;
            return el;
        end
        for (int w = 0; w < 4; w++) el.id[w] = rand_word();
        r = rand_word();
        el.out_index = r[31:0];
        el.amount = rand_word();
        r = rand_word();
        el.chain_height = r[31:0];
        if (mode < 50) begin
            // Removal of something that was never added.
            el.op = OP_REMOVE;
        end else begin
            el.op = OP_ADD;
            if (member_history.size() < HISTORY_LIMIT) member_history.push_back(el);
        end
        return el;
    endfunction

    task automatic send_element(input t_element el);
        while (!tx_quiet && $urandom_range(99) < STALL_PCT) begin
            elem_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        elem_ch.valid        <= 1'b1;
        elem_ch.op           <= el.op;
        elem_ch.id_word0     <= el.id[0];
        elem_ch.id_word1     <= el.id[1];
        elem_ch.id_word2     <= el.id[2];
        elem_ch.id_word3     <= el.id[3];
        elem_ch.out_index    <= el.out_index;
        elem_ch.amount       <= el.amount;
        elem_ch.chain_height <= el.chain_height;
        do @(posedge i_clk); while (!elem_ch.ready);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) send_element(random_element());
    endtask

    // Stop offering elements and wait until every predicted result has come.
    // The count is sampled on the falling edge, after the checker has updated.
    task automatic wait_idle();
        elem_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    task automatic write_skip(input logic skip);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.skip_updates <= skip;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, with an occasional long hold-off on request.
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= rx_quiet || ($urandom_range(99) >= STALL_PCT);
            @(posedge i_clk);
        end
    end

    initial begin
        #4_000_000;
        $display("xor_hash_set_accumulator verification failed");
        $finish;
    end

    initial begin
        t_element zero_elem;
        t_element ones_elem;
        t_element low_elem;
        t_element high_elem;
        t_element mixed_elem;
        elem_ch.valid        = 1'b0;
        elem_ch.op           = OP_ADD;
        elem_ch.id_word0     = '0;
        elem_ch.id_word1     = '0;
        elem_ch.id_word2     = '0;
        elem_ch.id_word3     = '0;
        elem_ch.out_index    = '0;
        elem_ch.amount       = '0;
        elem_ch.chain_height = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.skip_updates  = 1'b0;

        zero_elem  = make_element(OP_ADD, '0, '0, '0, '0);
        ones_elem  = make_element(OP_ADD, '1, '1, '1, '1);
        low_elem   = make_element(OP_ADD, 64'h5555_5555_5555_5555, 32'h0000_0000,
                                  64'h8000_0000_0000_0000, 32'h8000_0000);
        high_elem  = make_element(OP_ADD, 64'haaaa_aaaa_aaaa_aaaa, 32'hffff_ffff,
                                  64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff);
        mixed_elem = make_element(OP_ADD, 64'h0123_4567_89ab_cdef, 32'h0000_0001,
                                  64'h0000_0000_0000_0001, 32'h0000_0001);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_skip(1'b0);

        // Removal from an empty set still folds the digest in; the count holds at zero.
        zero_elem.op = OP_REMOVE;
        send_element(zero_elem);
        zero_elem.op = OP_ADD;
        send_element(zero_elem);
        zero_elem.op = OP_REMOVE;
        send_element(zero_elem);
        send_element(zero_elem);
        send_element(ones_elem);
        send_element(low_elem);
        send_element(high_elem);
        send_element(mixed_elem);
        ones_elem.op = OP_REMOVE;
        send_element(ones_elem);
        low_elem.op = OP_REMOVE;
        send_element(low_elem);
        for (int i = 0; i < 4; i++) send_element(random_element());
        high_elem.op = OP_REMOVE;
        send_element(high_elem);
        mixed_elem.op = OP_REMOVE;
        send_element(mixed_elem);

        // Frozen updates: the reported state must not move.
        wait_idle();
        write_skip(1'b1);
        ones_elem.op = OP_ADD;
        send_element(ones_elem);
        send_element(zero_elem);
        send_element(mixed_elem);
        send_element(random_element());
        wait_idle();
        write_skip(1'b0);

        send_random(100);

        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_random(60);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        send_random(40);

        // Long hold-off on the result side while elements keep coming, so the
        // digest queue fills and the element channel backs up.
        rx_hold_req = 1'b1;
        tx_quiet = 1'b1;
        send_random(120);
        tx_quiet = 1'b0;

        wait_idle();
        send_random(30);

        wait_idle();
        write_skip(1'b1);
        send_random(20);
        wait_idle();
        write_skip(1'b0);
        send_random(30);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("xor_hash_set_accumulator verification clean");
        end else begin
            $display("xor_hash_set_accumulator verification failed");
        end
        $finish;
    end

endmodule
